/* rtl/plq_pkg.sv */
package plq_pkg;

    localparam int SLOT_FIELD_W  = 8;
    localparam int ID_FIELD_W    = 32;
    localparam int QTY_FIELD_W   = 32;
    localparam int TOTAL_BITS    = 40;
    localparam int COUNT_FIELD_W = 9;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_UNLINK = 2'd1;
    localparam logic [1:0] OP_REDUCE = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_QUEUED     = 2'd1;
    localparam logic [1:0] ERR_NOT_QUEUED = 2'd2;
    localparam logic [1:0] ERR_EXCEEDS    = 2'd3;

    typedef struct packed {
        logic [1:0]              op;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [ID_FIELD_W-1:0]   order_id;
        logic [QTY_FIELD_W-1:0]  amount;
    } request_t;

    typedef struct packed {
        logic [1:0]               error;
        logic [COUNT_FIELD_W-1:0] order_count;
        logic [TOTAL_BITS-1:0]    total_quantity;
        logic                     front_valid;
        logic [SLOT_FIELD_W-1:0]  front_slot;
        logic [ID_FIELD_W-1:0]    front_order_id;
        logic                     slot_queued;
        logic [QTY_FIELD_W-1:0]   slot_quantity;
        logic                     next_valid;
        logic [SLOT_FIELD_W-1:0]  next_slot;
        logic                     prev_valid;
        logic [SLOT_FIELD_W-1:0]  prev_slot;
    } result_t;

endpackage

/* rtl/plq_ram.sv */
module plq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [WIDTH-1:0]         wmask,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // bit-masked write: only the selected fields of an entry change
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int i = 0; i < WIDTH; i++)
            begin
                if (wmask[i])
                begin
                    mem[waddr][i] <= wdata[i];
                end
            end
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/price_level_order_queue.sv */
// Price level order queue: one price level's time-ordered list of resting orders,
// kept as a doubly linked list over a pool of SLOTS order slots.
// Request channel: request is taken at a rising edge with start high and busy low.
// Result channel: done is high for one cycle with the result on result; the
// receiver has no way to hold it off, so it must take it in that cycle.
// Each request is one slot memory read, then the write back; an unlink of a slot
// that is not the tail also passes a link fix state, as its second neighbor fix goes
// through the same write port of the slot memory. A new request may be accepted in
// the cycle where the previous result is shown, unless the link fix state still
// holds busy high. Reset: head, tail, count and total clear at once; then a clearing
// pass marks every slot as not queued, with busy held high throughout.
// An erroring request leaves the state unchanged and still returns a result.
module price_level_order_queue #(
    parameter int SLOTS    = 256,
    parameter int QTY_BITS = 32,
    parameter int ID_BITS  = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  plq_pkg::request_t request,
    output logic              done,
    output plq_pkg::result_t  result
);

    import plq_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int AW     = 1 + QTY_BITS + SLOT_W;
    localparam int BW     = SLOT_W + ID_BITS;
    localparam int WRAP_N = 2 ** SLOT_FIELD_W;

    localparam logic [AW-1:0] MASK_ALL  = {AW{1'b1}};
    localparam logic [AW-1:0] MASK_Q    = {1'b1, {(QTY_BITS + SLOT_W){1'b0}}};
    localparam logic [AW-1:0] MASK_QTY  = {1'b0, {QTY_BITS{1'b1}}, {SLOT_W{1'b0}}};
    localparam logic [AW-1:0] MASK_PREV = {{(1 + QTY_BITS){1'b0}}, {SLOT_W{1'b1}}};

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_CLEAR   = 2'd1;
    localparam logic [1:0] ST_EXEC    = 2'd2;
    localparam logic [1:0] ST_UNLINK2 = 2'd3;

    typedef logic [WRAP_N-1:0][SLOT_W-1:0] wrap_table_t;

    function automatic wrap_table_t build_wrap_table();
        wrap_table_t t;
        for (int i = 0; i < WRAP_N; i++)
        begin
            t[i] = SLOT_W'(i % SLOTS);
        end
        return t;
    endfunction

    localparam wrap_table_t WRAP_TABLE = build_wrap_table();

    logic [1:0]            state_reg, state_next;
    logic [SLOT_W-1:0]     clear_idx_reg;
    logic [1:0]            op_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [ID_BITS-1:0]    id_reg;
    logic [QTY_BITS-1:0]   amt_reg;
    logic [SLOT_W-1:0]     head_reg, head_next;
    logic [SLOT_W-1:0]     tail_reg, tail_next;
    logic [ID_BITS-1:0]    head_id_reg, head_id_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic [SLOT_W-1:0]     p_reg;
    logic [SLOT_W-1:0]     n_reg;
    logic                  done_reg, done_next;
    result_t               result_reg, result_next;

    logic                  accept;
    logic [SLOT_W-1:0]     rd_addr;
    logic [AW-1:0]         a_rd;
    logic [BW-1:0]         b_rd;
    logic                  a_queued;
    logic [QTY_BITS-1:0]   a_qty;
    logic [SLOT_W-1:0]     a_prev;
    logic [SLOT_W-1:0]     b_next;
    logic [ID_BITS-1:0]    b_next_id;
    logic                  is_head;
    logic                  is_tail;
    logic [QTY_BITS-1:0]   qty_reduced;

    logic                  a_we;
    logic [SLOT_W-1:0]     a_waddr;
    logic [AW-1:0]         a_wdata;
    logic [AW-1:0]         a_wmask;
    logic                  b_we;
    logic [SLOT_W-1:0]     b_waddr;
    logic [BW-1:0]         b_wdata;

    logic [1:0]            err;
    logic                  q_after;
    logic [QTY_BITS-1:0]   qty_after;
    logic [SLOT_W-1:0]     prev_after;
    logic                  fv;
    logic                  nv;
    logic                  pv;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign rd_addr = WRAP_TABLE[request.slot];

    // per slot: queued flag, quantity, earlier link
    plq_ram #(
        .DEPTH (SLOTS),
        .WIDTH (AW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .wmask (a_wmask),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (a_rd)
    );

    // per slot: later link and the id of that later order
    plq_ram #(
        .DEPTH (SLOTS),
        .WIDTH (BW)
    ) u_link_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .wmask ({BW{1'b1}}),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (b_rd)
    );

    assign a_queued    = a_rd[AW-1];
    assign a_qty       = a_rd[AW-2:SLOT_W];
    assign a_prev      = a_rd[SLOT_W-1:0];
    assign b_next      = b_rd[BW-1:ID_BITS];
    assign b_next_id   = b_rd[ID_BITS-1:0];
    assign is_head     = (slot_reg == head_reg);
    assign is_tail     = (slot_reg == tail_reg);
    assign qty_reduced = a_qty - amt_reg;

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        head_id_next = head_id_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        done_next    = 1'b0;
        err          = ERR_OK;
        q_after      = a_queued;
        qty_after    = a_qty;
        prev_after   = a_prev;
        a_we         = 1'b0;
        a_waddr      = slot_reg;
        a_wdata      = '0;
        a_wmask      = '0;
        b_we         = 1'b0;
        b_waddr      = tail_reg;
        b_wdata      = {slot_reg, id_reg};

        case (state_reg)
            ST_CLEAR:
            begin
                a_we    = 1'b1;
                a_waddr = clear_idx_reg;
                a_wmask = MASK_Q;
                if (clear_idx_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                case (op_reg)
                    OP_PUSH:
                    begin
                        if (a_queued)
                        begin
                            err = ERR_QUEUED;
                        end
                        else
                        begin
                            a_we    = 1'b1;
                            a_wdata = {1'b1, amt_reg, tail_reg};
                            a_wmask = MASK_ALL;
                            if (count_reg != '0)
                            begin
                                b_we = 1'b1;
                            end
                            else
                            begin
                                head_next    = slot_reg;
                                head_id_next = id_reg;
                            end
                            tail_next  = slot_reg;
                            count_next = count_reg + CNT_W'(1);
                            total_next = total_reg + TOTAL_BITS'(amt_reg);
                            q_after    = 1'b1;
                            qty_after  = amt_reg;
                            prev_after = tail_reg;
                        end
                    end
                    OP_UNLINK:
                    begin
                        if (!a_queued)
                        begin
                            err = ERR_NOT_QUEUED;
                        end
                        else
                        begin
                            // drop the flag now, fix the later neighbor's link next cycle
                            a_we    = 1'b1;
                            a_wmask = MASK_Q;
                            if (!is_head)
                            begin
                                b_we    = 1'b1;
                                b_waddr = a_prev;
                                b_wdata = {b_next, b_next_id};
                            end
                            else
                            begin
                                head_next    = b_next;
                                head_id_next = b_next_id;
                            end
                            if (is_tail)
                            begin
                                tail_next = a_prev;
                            end
                            else
                            begin
                                state_next = ST_UNLINK2;
                            end
                            if (is_head && is_tail)
                            begin
                                head_next = '0;
                                tail_next = '0;
                            end
                            count_next = count_reg - CNT_W'(1);
                            total_next = total_reg - TOTAL_BITS'(a_qty);
                            q_after    = 1'b0;
                        end
                    end
                    OP_REDUCE:
                    begin
                        if (!a_queued)
                        begin
                            err = ERR_NOT_QUEUED;
                        end
                        else if (amt_reg > a_qty)
                        begin
                            err = ERR_EXCEEDS;
                        end
                        else
                        begin
                            a_we       = 1'b1;
                            a_wdata    = {1'b0, qty_reduced, {SLOT_W{1'b0}}};
                            a_wmask    = MASK_QTY;
                            total_next = total_reg - TOTAL_BITS'(amt_reg);
                            qty_after  = qty_reduced;
                        end
                    end
                    default:
                    begin
                        err = ERR_OK;
                    end
                endcase
            end
            ST_UNLINK2:
            begin
                a_we       = 1'b1;
                a_waddr    = n_reg;
                a_wdata    = {1'b0, {QTY_BITS{1'b0}}, p_reg};
                a_wmask    = MASK_PREV;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        fv = (count_next != '0);
        nv = q_after && (slot_reg != tail_next);
        pv = q_after && (slot_reg != head_next);

        result_next.error          = err;
        result_next.order_count    = COUNT_FIELD_W'(count_next);
        result_next.total_quantity = total_next;
        result_next.front_valid    = fv;
        result_next.front_slot     = fv ? SLOT_FIELD_W'(head_next) : '0;
        result_next.front_order_id = fv ? ID_FIELD_W'(head_id_next) : '0;
        result_next.slot_queued    = q_after;
        result_next.slot_quantity  = q_after ? QTY_FIELD_W'(qty_after) : '0;
        result_next.next_valid     = nv;
        result_next.next_slot      = nv ? SLOT_FIELD_W'(b_next) : '0;
        result_next.prev_valid     = pv;
        result_next.prev_slot      = pv ? SLOT_FIELD_W'(prev_after) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_idx_reg <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            head_id_reg   <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            head_id_reg <= head_id_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            done_reg    <= done_next;
            if (state_reg == ST_CLEAR)
            begin
                clear_idx_reg <= clear_idx_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= request.op;
            slot_reg <= rd_addr;
            id_reg   <= ID_BITS'(request.order_id);
            amt_reg  <= QTY_BITS'(request.amount);
        end
        if (state_reg == ST_EXEC)
        begin
            p_reg      <= a_prev;
            n_reg      <= b_next;
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == ST_EXEC)
        else $error("result strobe without an execute cycle");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_EXEC)
        else $error("accepted request did not enter execute");

    a_unlink2_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UNLINK2) |-> $past(state_reg) == ST_EXEC && $past(op_reg) == OP_UNLINK)
        else $error("link fix cycle without an unlink");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS))
        else $error("order count beyond pool size");

    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == '0 && tail_reg == '0))
        else $error("empty queue with nonzero head or tail");

endmodule
